FILE: src/smau_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the small matrix arithmetic unit.
package smau_pkg;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_SUB   = 2'd1,
		OP_SCALE = 2'd2,
		OP_MUL   = 2'd3
	} op_mode_t;

	typedef enum logic [1:0] {
		CMD_WR_A  = 2'd0,
		CMD_WR_B  = 2'd1,
		CMD_START = 2'd2
	} cmd_t;

	localparam logic [2:0] REG_OP_MODE      = 3'd0;
	localparam logic [2:0] REG_ROWS_A       = 3'd1;
	localparam logic [2:0] REG_COLS_A       = 3'd2;
	localparam logic [2:0] REG_COLS_B       = 3'd3;
	localparam logic [2:0] REG_SCALE_FACTOR = 3'd4;

	// settings seen by every cell
	typedef struct packed {
		op_mode_t    mode;
		logic [3:0]  ca;
		logic [31:0] scale;
	} cfg_t;

	// element write broadcast along the chain
	typedef struct packed {
		logic        a_en;
		logic        b_en;
		logic [2:0]  row;
		logic [2:0]  col;
		logic [31:0] data;
	} wr_t;

	// one result element travelling through the cells
	typedef struct packed {
		logic        valid;
		logic        last;
		logic [2:0]  row;
		logic [2:0]  col;
		logic [31:0] acc;
		logic [31:0] prod;
	} tok_t;

endpackage

FILE: src/smau_cell.sv
`timescale 1ns / 1ps
// One chain cell: holds column K of A and row K of B, adds its term to the passing element.
module smau_cell #(
	parameter int MAX_DIM = 8,
	parameter int K       = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  smau_pkg::cfg_t cfg,
	input  smau_pkg::wr_t  wr,
	input  smau_pkg::tok_t tok_in,
	output smau_pkg::tok_t tok_out
);
	import smau_pkg::*;

	localparam int         IW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam logic [2:0] KSEL = 3'(K);
	localparam logic [3:0] KDIM = 4'(K);

	logic [31:0] a_col_q [MAX_DIM];
	logic [31:0] b_row_q [MAX_DIM];

	logic        valid_q;
	logic        last_q;
	logic [2:0]  row_q;
	logic [2:0]  col_q;
	logic [31:0] acc_q;
	logic [31:0] prod_q;

	logic [31:0] a_v;
	logic [31:0] b_v;
	logic [31:0] mul_y;
	logic [31:0] mul_p;
	logic [31:0] a_term;
	logic [31:0] b_term;
	logic [31:0] prod_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < MAX_DIM; n++) begin
				a_col_q[n] <= '0;
				b_row_q[n] <= '0;
			end
		end else begin
			if (wr.a_en && wr.col == KSEL) begin
				a_col_q[wr.row[IW-1:0]] <= wr.data;
			end
			if (wr.b_en && wr.row == KSEL) begin
				b_row_q[wr.col[IW-1:0]] <= wr.data;
			end
		end
	end

	always_comb begin
		a_v    = a_col_q[tok_in.row[IW-1:0]];
		b_v    = b_row_q[tok_in.col[IW-1:0]];
		mul_y  = (cfg.mode == OP_MUL) ? b_v : cfg.scale;
		mul_p  = a_v * mul_y;
		a_term = (tok_in.col == KSEL) ? a_v : '0;
		b_term = '0;
		if (tok_in.row == KSEL) begin
			b_term = (cfg.mode == OP_SUB) ? 32'(32'd0 - b_v) : b_v;
		end
		case (cfg.mode)
			OP_MUL:   prod_d = (KDIM < cfg.ca) ? mul_p : '0;
			OP_SCALE: prod_d = (tok_in.col == KSEL) ? mul_p : '0;
			default:  prod_d = a_term + b_term;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_q <= tok_in.last;
			row_q  <= tok_in.row;
			col_q  <= tok_in.col;
			acc_q  <= tok_in.acc + tok_in.prod;
			prod_q <= prod_d;
		end
	end

	assign tok_out = '{valid: valid_q, last: last_q, row: row_q, col: col_q,
		acc: acc_q, prod: prod_q};

endmodule

FILE: src/smau_seq.sv
`timescale 1ns / 1ps
// Issue sequencer: walks the result shape in row-major order and feeds the cell chain.
module smau_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          start,
	input  logic          done,
	input  logic [3:0]    ra,
	input  logic [3:0]    oc,
	output smau_pkg::tok_t tok,
	output logic          busy
);
	import smau_pkg::*;

	logic       issuing_q;
	logic       busy_q;
	logic [2:0] i_q;
	logic [2:0] j_q;
	logic       row_end;
	logic       col_end;

	assign col_end = ({1'b0, j_q} == oc - 4'd1);
	assign row_end = ({1'b0, i_q} == ra - 4'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issuing_q <= 1'b0;
			busy_q    <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
		end else begin
			if (start) begin
				issuing_q <= 1'b1;
				busy_q    <= 1'b1;
				i_q       <= '0;
				j_q       <= '0;
			end else begin
				if (done) begin
					busy_q <= 1'b0;
				end
				if (adv && issuing_q) begin
					if (col_end) begin
						j_q <= '0;
						if (row_end) begin
							issuing_q <= 1'b0;
						end else begin
							i_q <= i_q + 3'd1;
						end
					end else begin
						j_q <= j_q + 3'd1;
					end
				end
			end
		end
	end

	assign tok  = '{valid: issuing_q, last: row_end && col_end, row: i_q, col: j_q,
		acc: 32'd0, prod: 32'd0};
	assign busy = busy_q;

endmodule

FILE: src/small_matrix_arithmetic_unit.sv
`timescale 1ns / 1ps
// Top level: element stores in a chain of MAX_DIM cells, add/sub/scale/multiply of A and B.
// Writes are taken while no start is busy (cmd_stall low); a start is answered by rows x cols result beats.
// Each element passes the MAX_DIM cell registers and the output register; result beats then
// leave one per cycle while res_stall is low.
// No command is taken from a start until its last result beat leaves.
// Reset clears both stores to zero and loads the register defaults at once.
module small_matrix_arithmetic_unit #(
	parameter int MAX_DIM = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic [1:0]         command,
	input  logic [2:0]         row_index,
	input  logic [2:0]         col_index,
	input  logic signed [31:0] element_value,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [2:0]         out_row,
	output logic [2:0]         out_col,
	output logic signed [31:0] out_value,
	output logic               last_element
);
	import smau_pkg::*;

	function automatic logic [3:0] eff_dim(input logic [3:0] d);
		logic [3:0] r;
		r = d;
		if (d == 4'd0) r = 4'd1;
		if (d > 4'(MAX_DIM)) r = 4'(MAX_DIM);
		return r;
	endfunction

	op_mode_t    op_mode_q;
	logic [3:0]  rows_a_q;
	logic [3:0]  cols_a_q;
	logic [3:0]  cols_b_q;
	logic [31:0] scale_q;

	logic [3:0]  ra;
	logic [3:0]  ca;
	logic [3:0]  cb;
	logic [3:0]  oc;
	logic [3:0]  br;
	logic [3:0]  bc;
	logic        is_mul;

	logic        cmd_acc;
	logic        start;
	logic        done;
	logic        busy;
	logic        adv;
	cfg_t        cfg;
	wr_t         wr;
	tok_t        chain [MAX_DIM+1];

	logic        res_valid_q;
	logic [2:0]  out_row_q;
	logic [2:0]  out_col_q;
	logic [31:0] out_value_q;
	logic        last_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_mode_q <= OP_ADD;
			rows_a_q  <= 4'd8;
			cols_a_q  <= 4'd8;
			cols_b_q  <= 4'd8;
			scale_q   <= 32'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_OP_MODE:      op_mode_q <= op_mode_t'(cfg_data[1:0]);
				REG_ROWS_A:       rows_a_q  <= cfg_data[3:0];
				REG_COLS_A:       cols_a_q  <= cfg_data[3:0];
				REG_COLS_B:       cols_b_q  <= cfg_data[3:0];
				REG_SCALE_FACTOR: scale_q   <= cfg_data;
				default:          ;
			endcase
		end
	end

	always_comb begin
		ra     = eff_dim(rows_a_q);
		ca     = eff_dim(cols_a_q);
		cb     = eff_dim(cols_b_q);
		is_mul = (op_mode_q == OP_MUL);
		oc     = is_mul ? cb : ca;
		br     = is_mul ? ca : ra;
		bc     = is_mul ? cb : ca;
	end

	assign cmd_stall = busy;
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign start     = cmd_acc && (command == CMD_START);
	assign adv       = !res_valid_q || !res_stall;
	assign done      = res_valid_q && !res_stall && last_q;

	always_comb begin
		wr.a_en = cmd_acc && (command == CMD_WR_A) &&
			({1'b0, row_index} < ra) && ({1'b0, col_index} < ca);
		wr.b_en = cmd_acc && (command == CMD_WR_B) &&
			({1'b0, row_index} < br) && ({1'b0, col_index} < bc);
		wr.row  = row_index;
		wr.col  = col_index;
		wr.data = element_value;
	end

	assign cfg = '{mode: op_mode_q, ca: ca, scale: scale_q};

	smau_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.start  (start),
		.done   (done),
		.ra     (ra),
		.oc     (oc),
		.tok    (chain[0]),
		.busy   (busy)
	);

	for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
		smau_cell #(
			.MAX_DIM (MAX_DIM),
			.K       (k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.cfg     (cfg),
			.wr      (wr),
			.tok_in  (chain[k]),
			.tok_out (chain[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= chain[MAX_DIM].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_row_q   <= chain[MAX_DIM].row;
			out_col_q   <= chain[MAX_DIM].col;
			out_value_q <= chain[MAX_DIM].acc + chain[MAX_DIM].prod;
			last_q      <= chain[MAX_DIM].last;
		end
	end

	assign res_valid    = res_valid_q;
	assign out_row      = out_row_q;
	assign out_col      = out_col_q;
	assign out_value    = out_value_q;
	assign last_element = last_q;

endmodule

FILE: verif/smau_checker.sv
`timescale 1ns / 1ps
// Checker for the small matrix arithmetic unit: mirrors the stores, predicts and compares beats.
module smau_checker #(
	parameter int MAX_DIM = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        cmd_valid,
	input  logic        cmd_stall,
	input  logic [1:0]  command,
	input  logic [2:0]  row_index,
	input  logic [2:0]  col_index,
	input  logic [31:0] element_value,
	input  logic        res_valid,
	input  logic        res_stall,
	input  logic [2:0]  out_row,
	input  logic [2:0]  out_col,
	input  logic [31:0] out_value,
	input  logic        last_element,
	output int          elems_due,
	output int          elems_checked,
	output int          mismatches
);
	import smau_pkg::*;

	typedef struct packed {
		logic [2:0]  row;
		logic [2:0]  col;
		logic [31:0] value;
		logic        last;
	} elem_t;

	logic [31:0] a_mem [MAX_DIM*MAX_DIM];
	logic [31:0] b_mem [MAX_DIM*MAX_DIM];
	op_mode_t    mode;
	logic [3:0]  n_rows;
	logic [3:0]  n_cols;
	logic [3:0]  n_cols_b;
	logic [31:0] factor;
	elem_t       result_elems_due[$];
	int          checked_n = 0;
	int          fail_n = 0;

	function automatic int clamp_dim(logic [3:0] d);
		if (d == 4'd0)
			return 1;
		if (d > MAX_DIM)
			return MAX_DIM;
		return int'(d);
	endfunction

	// whole result matrix, row-major, last flag on the final element
	function automatic void queue_result_matrix();
		int          ra;
		int          ca;
		int          oc;
		int          n;
		logic [31:0] acc;
		elem_t       e;
		ra = clamp_dim(n_rows);
		ca = clamp_dim(n_cols);
		oc = (mode == OP_MUL) ? clamp_dim(n_cols_b) : ca;
		n = 0;
		for (int i = 0; i < ra; i++) begin
			for (int j = 0; j < oc; j++) begin
				case (mode)
					OP_ADD:   acc = a_mem[i*MAX_DIM+j] + b_mem[i*MAX_DIM+j];
					OP_SUB:   acc = a_mem[i*MAX_DIM+j] - b_mem[i*MAX_DIM+j];
					OP_SCALE: acc = factor * a_mem[i*MAX_DIM+j];
					default: begin
						acc = '0;
						for (int k = 0; k < ca; k++)
							acc = acc + a_mem[i*MAX_DIM+k] * b_mem[k*MAX_DIM+j];
					end
				endcase
				n++;
				e.row   = 3'(i);
				e.col   = 3'(j);
				e.value = acc;
				e.last  = (n == ra * oc);
				result_elems_due.push_back(e);
			end
		end
	endfunction

	// B shape follows the mode at the time of the write
	function automatic void apply_command(logic [1:0] cmd, logic [2:0] r, logic [2:0] c,
			logic [31:0] v);
		int ra;
		int ca;
		int br;
		int bc;
		ra = clamp_dim(n_rows);
		ca = clamp_dim(n_cols);
		br = (mode == OP_MUL) ? ca : ra;
		bc = (mode == OP_MUL) ? clamp_dim(n_cols_b) : ca;
		case (cmd)
			CMD_WR_A: if (r < ra && c < ca) a_mem[r*MAX_DIM+c] = v;
			CMD_WR_B: if (r < br && c < bc) b_mem[r*MAX_DIM+c] = v;
			CMD_START: queue_result_matrix();
			default: ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		elem_t got;
		elem_t want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_DIM*MAX_DIM; i++) begin
				a_mem[i] = '0;
				b_mem[i] = '0;
			end
			mode     = OP_ADD;
			n_rows   = 4'(MAX_DIM);
			n_cols   = 4'(MAX_DIM);
			n_cols_b = 4'(MAX_DIM);
			factor   = 32'd1;
			result_elems_due.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_OP_MODE:      mode = op_mode_t'(cfg_data[1:0]);
					REG_ROWS_A:       n_rows = cfg_data[3:0];
					REG_COLS_A:       n_cols = cfg_data[3:0];
					REG_COLS_B:       n_cols_b = cfg_data[3:0];
					REG_SCALE_FACTOR: factor = cfg_data;
					default: ;
				endcase
			end
			if (cmd_valid && !cmd_stall)
				apply_command(command, row_index, col_index, element_value);
			if (res_valid && !res_stall) begin
				got = {out_row, out_col, out_value, last_element};
				if (result_elems_due.size() == 0) begin
					fail_n++;
					if (fail_n <= 10)
						$display("unexpected result beat: row %0d col %0d value %0d last %0d",
							got.row, got.col, $signed(got.value), got.last);
				end else begin
					want = result_elems_due.pop_front();
					checked_n++;
					if (got.row !== want.row || got.col !== want.col ||
							got.value !== want.value || got.last !== want.last) begin
						fail_n++;
						if (fail_n <= 10) begin
							$write("result mismatch: expected row %0d col %0d value %0d last %0d, ",
								want.row, want.col, $signed(want.value), want.last);
							$display("got row %0d col %0d value %0d last %0d",
								got.row, got.col, $signed(got.value), got.last);
						end
					end
				end
			end
		end
		elems_due     <= result_elems_due.size();
		elems_checked <= checked_n;
		mismatches    <= fail_n;
	end

endmodule

FILE: verif/tb_small_matrix_arithmetic_unit.sv
`timescale 1ns / 1ps
// Testbench top for the small matrix arithmetic unit: stimulus, flow control, watchdog and verdict.
module tb_small_matrix_arithmetic_unit;
	import smau_pkg::*;

	localparam int         MAX_DIM      = 8;
	localparam int         IDLE_LIMIT   = 2000;
	localparam int         ITEM_TARGET  = 220;
	localparam logic [1:0] CMD_SPARE    = 2'd3;
	localparam logic [2:0] REG_SPARE    = 3'd7;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_style_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;
	logic               cmd_valid = 1'b0;
	logic               cmd_stall;
	logic [1:0]         command = '0;
	logic [2:0]         row_index = '0;
	logic [2:0]         col_index = '0;
	logic signed [31:0] element_value = '0;
	logic               res_valid;
	logic               res_stall = 1'b0;
	logic [2:0]         out_row;
	logic [2:0]         out_col;
	logic signed [31:0] out_value;
	logic               last_element;

	int           elems_due;
	int           elems_checked;
	int           mismatches;
	int           items_sent = 0;
	int           starts_sent = 0;
	int           settings_loaded = 0;
	int           burst_left = 0;
	int           idle_cycles = 0;
	int           stall_left = 0;
	stall_style_t stall_style = STALL_NONE;

	small_matrix_arithmetic_unit #(.MAX_DIM(MAX_DIM)) DUT (.*);

	smau_checker #(.MAX_DIM(MAX_DIM)) u_checker (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver back-pressure, style picked at random each time its countdown runs out
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_style <= stall_style_t'($urandom_range(0, 3));
			stall_left  <= $urandom_range(20, 120);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_style)
			STALL_NONE:  res_stall <= 1'b0;
			STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: res_stall <= ($urandom_range(0, 9) < 7);
			default:     res_stall <= ((stall_left % 5) < 2);
		endcase
	end

	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: %0d cycles without a beat, %0d result beats still due",
				IDLE_LIMIT, elems_due);
			$display("tb_small_matrix_arithmetic_unit failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic int shape_dim(logic [3:0] d);
		if (d == 4'd0)
			return 1;
		return (d > MAX_DIM) ? MAX_DIM : int'(d);
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '1;
			3: return 32'($urandom_range(0, 15)) - 32'd8;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [3:0] pick_dim();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll == 0)
			return 4'd0;
		if (roll == 1)
			return 4'($urandom_range(9, 15));
		if (roll == 2)
			return 4'(MAX_DIM);
		return 4'($urandom_range(1, 4));
	endfunction

	// one command beat; bursts of random length with random gaps between them
	task automatic send_item(input logic [1:0] cmd, input logic [2:0] r, input logic [2:0] c,
			input logic [31:0] v);
		int gap;
		if (burst_left == 0) begin
			@(negedge clk);
			cmd_valid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
		end else begin
			@(negedge clk);
		end
		cmd_valid     <= 1'b1;
		command       <= cmd;
		row_index     <= r;
		col_index     <= c;
		element_value <= v;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		burst_left--;
		if (cmd != CMD_SPARE)
			items_sent++;
		if (cmd == CMD_START)
			starts_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (elems_due != 0) @(negedge clk);
		repeat (MAX_DIM + 4) @(negedge clk);
		burst_left = 0;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// upper bits of the narrow registers carry junk
	task automatic load_settings(input op_mode_t m, input logic [3:0] ra, input logic [3:0] ca,
			input logic [3:0] cb, input logic [31:0] f);
		logic [31:0] junk;
		drain();
		junk = $urandom;
		write_reg(REG_OP_MODE, {junk[31:2], m});
		write_reg(REG_ROWS_A, {junk[27:0], ra});
		write_reg(REG_COLS_A, {junk[31:4], ca});
		write_reg(REG_COLS_B, {junk[29:2], cb});
		write_reg(REG_SCALE_FACTOR, f);
		write_reg(REG_SPARE, junk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings_loaded++;
	endtask

	initial begin : stimulus
		op_mode_t   m;
		logic [3:0] ra;
		logic [3:0] ca;
		logic [3:0] cb;
		int         rows_eff;
		int         cols_eff;
		int         b_rows;
		int         b_cols;
		int         roll;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// defaults after reset: 8x8 add of two empty stores
		send_item(CMD_START, 3'd0, 3'd0, 32'd0);

		load_settings(OP_ADD, 4'd8, 4'd8, 4'd8, 32'd1);
		send_item(CMD_WR_A, 3'd0, 3'd0, 32'h8000_0000);
		send_item(CMD_WR_B, 3'd0, 3'd0, '1);
		send_item(CMD_WR_A, 3'd7, 3'd7, 32'h7fff_ffff);
		send_item(CMD_WR_B, 3'd7, 3'd7, 32'd1);
		send_item(CMD_SPARE, 3'd7, 3'd7, '1);
		send_item(CMD_START, 3'd7, 3'd7, '1);

		// writes past the shape are dropped
		load_settings(OP_SUB, 4'd3, 4'd2, 4'd8, 32'd1);
		send_item(CMD_WR_A, 3'd2, 3'd1, 32'h8000_0000);
		send_item(CMD_WR_B, 3'd2, 3'd1, 32'd1);
		send_item(CMD_WR_A, 3'd3, 3'd0, 32'd5);
		send_item(CMD_WR_B, 3'd0, 3'd2, 32'd6);
		send_item(CMD_START, 3'd0, 3'd0, 32'd0);

		// zero dimension acts as one, oversize as the maximum
		load_settings(OP_SCALE, 4'd0, 4'd15, 4'd8, '1);
		send_item(CMD_WR_A, 3'd0, 3'd7, 32'h7fff_ffff);
		send_item(CMD_START, 3'd0, 3'd0, 32'd0);
		load_settings(OP_SCALE, 4'd8, 4'd8, 4'd1, 32'h8000_0000);
		send_item(CMD_START, 3'd0, 3'd0, 32'd0);

		// dot product, outer product, full product
		load_settings(OP_MUL, 4'd1, 4'd8, 4'd1, 32'h7fff_ffff);
		send_item(CMD_WR_B, 3'd7, 3'd0, '1);
		send_item(CMD_WR_A, 3'd0, 3'd7, 32'd3);
		send_item(CMD_WR_B, 3'd0, 3'd1, 32'd9);
		send_item(CMD_START, 3'd0, 3'd0, 32'd0);
		load_settings(OP_MUL, 4'd8, 4'd1, 4'd8, 32'd0);
		send_item(CMD_START, 3'd0, 3'd0, 32'd0);
		load_settings(OP_MUL, 4'd8, 4'd8, 4'd8, 32'd1);
		send_item(CMD_START, 3'd0, 3'd0, 32'd0);

		while (items_sent < ITEM_TARGET) begin
			m  = op_mode_t'($urandom_range(0, 3));
			ra = pick_dim();
			ca = pick_dim();
			cb = pick_dim();
			load_settings(m, ra, ca, cb, pick_value());
			rows_eff = shape_dim(ra);
			cols_eff = shape_dim(ca);
			b_rows   = (m == OP_MUL) ? cols_eff : rows_eff;
			b_cols   = (m == OP_MUL) ? shape_dim(cb) : cols_eff;
			repeat ($urandom_range(2, 12)) begin
				roll = $urandom_range(0, 9);
				if (roll == 0)
					send_item(CMD_SPARE, 3'($urandom), 3'($urandom), $urandom);
				else if (roll == 1)
					send_item(2'($urandom_range(0, 1)), 3'($urandom), 3'($urandom), pick_value());
				else if (roll < 6)
					send_item(CMD_WR_A, 3'($urandom_range(0, rows_eff - 1)),
						3'($urandom_range(0, cols_eff - 1)), pick_value());
				else
					send_item(CMD_WR_B, 3'($urandom_range(0, b_rows - 1)),
						3'($urandom_range(0, b_cols - 1)), pick_value());
			end
			repeat ($urandom_range(1, 2))
				send_item(CMD_START, 3'($urandom), 3'($urandom), $urandom);
		end

		drain();
		$display("%0d command beats with %0d starts over %0d register settings",
			items_sent, starts_sent, settings_loaded);
		$display("%0d result beats checked, %0d mismatches", elems_checked, mismatches);
		if (mismatches == 0 && elems_due == 0)
			$display("tb_small_matrix_arithmetic_unit passed");
		else
			$display("tb_small_matrix_arithmetic_unit failed");
		$finish;
	end

endmodule
